>>> rtl/maxp_pkg.sv
// Shared constants and helpers for the 2x2 stride-2 max-pooling block.
package maxp_pkg;

  // Default size limits of the line store and the position counters.
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // Image shape after reset.
  localparam int RESET_WIDTH  = 129;
  localparam int RESET_HEIGHT = 97;

  // Width of the image_width and image_height registers.
  localparam int DIM_W = 11;

  // Register indexes, decoded from paddr[2].
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // Field widths of one result beat.
  localparam int PIX_W = 8;
  localparam int IDX_W = 9;

  // Larger of two unsigned samples.
  function automatic logic [PIX_W-1:0] max_u8(logic [PIX_W-1:0] a, logic [PIX_W-1:0] b);
    return (a > b) ? a : b;
  endfunction

  // Index of the last row or column for a register value: zero counts as one,
  // and anything above the limit saturates to it.
  function automatic logic [31:0] dim_last(logic [DIM_W-1:0] v, logic [31:0] maxv);
    logic [31:0] wide;
    wide = {{(32-DIM_W){1'b0}}, v};
    if (v == '0) begin
      return 32'd0;
    end else if (wide > maxv) begin
      return maxv - 32'd1;
    end else begin
      return wide - 32'd1;
    end
  endfunction

endpackage

>>> rtl/maxpool_2x2_stride2_u8.sv
// 2x2 stride-2 max pooling over an unsigned 8-bit pixel stream.
//
// Pixels enter one per beat in raster order, and the block takes one every
// clock as long as results are drained. Each pixel that closes a pair passes
// an input stage (position decode, horizontal pair maximum, line store read);
// one that completes a window then passes a result register, where its
// result is valid. While a result waits in the result register, pixels that
// only open a pair or only store an even-row maximum still enter. The next
// pixel that completes a window waits in the input stage and holds off the
// input. Even rows keep their pair maxima in a line store of (MAX_WIDTH+1)/2
// bytes with one write port and one read port. Odd rows, and an unpaired last
// row, emit one result per pair, with tlast on the frame's last result.
// Writing either size register restarts the frame at row 0, column 0; only
// write them while no pixel is in flight.
module maxpool_2x2_stride2_u8
  import maxp_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] pixel
  // Result stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [7:0] pooled, [16:8] out_col, [25:17] out_row, rest zero
  output logic        m_tlast,   // frame_end
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int CW = ($clog2(MAX_WIDTH) > 2) ? $clog2(MAX_WIDTH) : 2;
  localparam int RW = ($clog2(MAX_HEIGHT) > 2) ? $clog2(MAX_HEIGHT) : 2;
  localparam int AW = CW - 1;
  localparam int LINE_DEPTH = (MAX_WIDTH + 1) / 2;

  // Configuration registers and their clamped last indexes.
  logic [DIM_W-1:0] width_cfg;
  logic [DIM_W-1:0] height_cfg;
  logic [CW-1:0]    last_x;
  logic [RW-1:0]    last_y;

  // Frame position and the pending left pixel of a pair.
  logic [CW-1:0]    col_pos;
  logic [RW-1:0]    row_pos;
  logic [PIX_W-1:0] left_pixel;

  // Input stage.
  logic             s1_valid;
  logic             s1_wr;
  logic             s1_odd;
  logic             s1_last;
  logic [PIX_W-1:0] s1_hmax;
  logic [AW-1:0]    s1_slot;
  logic [RW-2:0]    s1_oy;
  logic [PIX_W-1:0] rd_data;

  // Line store of even-row pair maxima.
  logic [PIX_W-1:0] line_mem [LINE_DEPTH];

  // Result register.
  logic [PIX_W-1:0] out_pooled;
  logic [IDX_W-1:0] out_col;
  logic [IDX_W-1:0] out_row;
  logic             out_last;

  logic             cfg_wr;
  logic             in_fire;
  logic             s1_advance;
  logic             wr_en;
  logic             last_col;
  logic             last_row;
  logic             have_pair;
  logic [PIX_W-1:0] hmax;
  logic [AW-1:0]    rd_slot;
  logic [PIX_W-1:0] pooled_next;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // Register read-back.
  always_comb begin
    case (paddr[2])
      REG_WIDTH:  prdata = {{(32-DIM_W){1'b0}}, width_cfg};
      REG_HEIGHT: prdata = {{(32-DIM_W){1'b0}}, height_cfg};
      default:    prdata = '0;
    endcase
  end

  // Handshake: the input stage moves on when its item only writes the line
  // store or when the result register is free or being drained.
  assign s1_advance = s1_valid && (s1_wr || !m_tvalid || m_tready);
  assign s_tready   = !s1_valid || s1_advance;
  assign in_fire    = s_tvalid && s_tready;
  assign wr_en      = s1_advance && s1_wr;

  // Position decode and horizontal pair maximum.
  assign last_col  = (col_pos == last_x);
  assign last_row  = (row_pos == last_y);
  assign have_pair = col_pos[0] || last_col;
  assign hmax      = col_pos[0] ? max_u8(left_pixel, s_tdata) : s_tdata;
  assign rd_slot   = col_pos[CW-1:1];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      width_cfg  <= DIM_W'(RESET_WIDTH);
      height_cfg <= DIM_W'(RESET_HEIGHT);
      last_x     <= CW'(dim_last(DIM_W'(RESET_WIDTH), 32'(MAX_WIDTH)));
      last_y     <= RW'(dim_last(DIM_W'(RESET_HEIGHT), 32'(MAX_HEIGHT)));
    end else if (cfg_wr) begin
      case (paddr[2])
        REG_WIDTH: begin
          width_cfg <= pwdata[DIM_W-1:0];
          last_x    <= CW'(dim_last(pwdata[DIM_W-1:0], 32'(MAX_WIDTH)));
        end
        REG_HEIGHT: begin
          height_cfg <= pwdata[DIM_W-1:0];
          last_y     <= RW'(dim_last(pwdata[DIM_W-1:0], 32'(MAX_HEIGHT)));
        end
        default: begin
        end
      endcase
    end
  end

  // Raster position; a register write restarts the frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos    <= '0;
      row_pos    <= '0;
      left_pixel <= '0;
    end else if (cfg_wr) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (in_fire) begin
      if (!have_pair) begin
        left_pixel <= s_tdata;
      end
      if (last_col) begin
        col_pos <= '0;
        row_pos <= last_row ? '0 : row_pos + RW'(1);
      end else begin
        col_pos <= col_pos + CW'(1);
      end
    end
  end

  // Input stage control.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= have_pair;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Input stage payload.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_hmax <= hmax;
      s1_slot <= rd_slot;
      s1_oy   <= row_pos[RW-1:1];
      s1_odd  <= row_pos[0];
      s1_wr   <= !row_pos[0] && !last_row;
      s1_last <= last_col && last_row;
    end
  end

  // Line store: write from the input stage, read as the pixel is taken. A
  // write to the slot being read in the same cycle is forwarded.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_mem[s1_slot] <= s1_hmax;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (wr_en && (s1_slot == rd_slot)) begin
        rd_data <= s1_hmax;
      end else begin
        rd_data <= line_mem[rd_slot];
      end
    end
  end

  // Vertical maximum against the stored even-row pair on odd rows; an unpaired last row passes its pair maximum.
  assign pooled_next = s1_odd ? max_u8(rd_data, s1_hmax) : s1_hmax;

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_advance && !s1_wr) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && !s1_wr) begin
      out_pooled <= pooled_next;
      out_col    <= IDX_W'(s1_slot);
      out_row    <= IDX_W'(s1_oy);
      out_last   <= s1_last;
    end
  end

  assign m_tdata = {{(32-PIX_W-2*IDX_W){1'b0}}, out_row, out_col, out_pooled};
  assign m_tlast = out_last;

endmodule

>>> rtl/maxp_checker.sv
// Port-level assertions for the max-pooling block, bound to its top level.
module maxp_checker
  import maxp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast,
  input logic        psel,
  input logic        penable,
  input logic        pwrite,
  input logic [2:0]  paddr,
  input logic [31:0] pwdata,
  input logic [31:0] prdata,
  input logic        pready
);

  logic after_last;

  // Remember whether the last result beat closed a frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      after_last <= 1'b1;
    end else if (m_tvalid && m_tready) begin
      after_last <= m_tlast;
    end
  end

  // A stalled result beat keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("result beat changed while stalled");

  // A result that shows up after an idle result side comes from a pixel that
  // was taken and then held in the input stage.
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
    else $error("result beat without a preceding pixel");

  // The first result of a frame is at output row 0, column 0.
  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && after_last |-> (m_tdata[25:8] == 18'd0))
    else $error("frame does not start at the origin");

  // A register write reads back on the next cycle.
  a_cfg_readback: assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite && pready |=>
      !(psel && !pwrite && (paddr[2] == $past(paddr[2]))) ||
      (prdata[DIM_W-1:0] == $past(pwdata[DIM_W-1:0])))
    else $error("register read-back mismatch");

  // The configuration port never waits.
  a_pready: assert property (@(posedge clk) disable iff (rst) pready)
    else $error("pready low");

endmodule

bind maxpool_2x2_stride2_u8 maxp_checker u_maxp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast),
  .psel     (psel),
  .penable  (penable),
  .pwrite   (pwrite),
  .paddr    (paddr),
  .pwdata   (pwdata),
  .prdata   (prdata),
  .pready   (pready)
);
